// ===== sv/mlbr_pkg.sv =====
package mlbr_pkg;

   localparam int LIMBS     = 4;
   localparam int LIMB_W    = 52;
   localparam int HALF_W    = LIMB_W / 2;
   localparam int COEF_W    = LIMBS * LIMB_W;
   localparam int PROD_W    = COEF_W + LIMB_W;
   localparam int QLIMBS    = LIMBS - 1;
   localparam int SHIFT_W   = 8;
   localparam int STAGES    = 9;
   localparam int CSR_IDX_W = 3;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(COEF_W);

   typedef logic [LIMB_W-1:0]   limb_type;
   typedef logic [COEF_W-1:0]   coef_type;
   typedef logic [PROD_W-1:0]   prod_type;
   typedef logic [2*LIMB_W-1:0] wide_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_Q_LIMB_0    = 3'd0,
      CSR_Q_LIMB_1    = 3'd1,
      CSR_Q_LIMB_2    = 3'd2,
      CSR_BARRETT     = 3'd3,
      CSR_SHIFT_K     = 3'd4
   } csr_idx_type;

endpackage

// ===== sv/mlbr_if.sv =====
interface mlbr_req_if;
   import mlbr_pkg::*;
   logic     valid;
   logic     ready;
   limb_type coef_limb_0;
   limb_type coef_limb_1;
   limb_type coef_limb_2;
   limb_type coef_limb_3;
   modport source (output valid, coef_limb_0, coef_limb_1, coef_limb_2, coef_limb_3,
                   input ready);
   modport sink (input valid, coef_limb_0, coef_limb_1, coef_limb_2, coef_limb_3,
                 output ready);
endinterface

interface mlbr_rsp_if;
   import mlbr_pkg::*;
   logic     valid;
   logic     ready;
   limb_type res_limb_0;
   limb_type res_limb_1;
   limb_type res_limb_2;
   limb_type res_limb_3;
   modport source (output valid, res_limb_0, res_limb_1, res_limb_2, res_limb_3,
                   input ready);
   modport sink (input valid, res_limb_0, res_limb_1, res_limb_2, res_limb_3,
                 output ready);
endinterface

// ===== sv/mlbr_limb_mul.sv =====
module mlbr_limb_mul (
   input  logic               clock,
   input  logic               en_a,
   input  logic               en_b,
   input  mlbr_pkg::limb_type a,
   input  mlbr_pkg::limb_type b,
   output mlbr_pkg::wide_type prod
);
   import mlbr_pkg::*;

   logic [LIMB_W-1:0] p00_ff, p01_ff, p10_ff, p11_ff;
   wide_type          prod_ff, prod_in;

   always_ff @(posedge clock) begin
      if (en_a) begin
         p00_ff <= a[HALF_W-1:0]      * b[HALF_W-1:0];
         p01_ff <= a[HALF_W-1:0]      * b[LIMB_W-1:HALF_W];
         p10_ff <= a[LIMB_W-1:HALF_W] * b[HALF_W-1:0];
         p11_ff <= a[LIMB_W-1:HALF_W] * b[LIMB_W-1:HALF_W];
      end
   end

   always_comb begin
      prod_in = (2*LIMB_W)'(p00_ff)
              + ((2*LIMB_W)'(p01_ff) << HALF_W)
              + ((2*LIMB_W)'(p10_ff) << HALF_W)
              + ((2*LIMB_W)'(p11_ff) << LIMB_W);
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;
endmodule

// ===== sv/multi_limb_barrett_reduce.sv =====
// Multi-limb Barrett reduction of one 208-bit coefficient (four 52-bit limbs).
// req_ch: coefficient transactions, valid/ready, limb 0 least significant.
// rsp_ch: reduced coefficient transactions, valid/ready, same limb order.
// csr_*: write-only registers q_limb_0..2, barrett_factor, shift_k, one per
// cycle when csr_we is high; write them only while no transaction is in flight.
// Throughput: one transaction per cycle while rsp_ch is not stalled. Every
// accepted request passes through the nine-stage pipeline in order: a 26x26
// partial-product stage and a sum stage for x*m, the 260-bit product add, the
// quotient window shift, a partial-product stage and a sum stage for
// q*quotient, the q*quotient limb combine, and two 208-bit subtracts.
// Each stage has its own valid bit; a stage loads when it is empty or its
// successor loads, so bubbles close up while rsp_ch is stalled and req_ch is
// refused only once every stage holds a transaction. A stalled response
// holds its value. Reset empties the pipeline and loads q = 0, m = 0, k = 208.
module multi_limb_barrett_reduce (
   input  logic                           clock,
   input  logic                           reset,
   mlbr_req_if.sink                       req_ch,
   mlbr_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [mlbr_pkg::CSR_IDX_W-1:0] csr_index,
   input  mlbr_pkg::limb_type             csr_wdata
);
   import mlbr_pkg::*;

   limb_type             q_ff [QLIMBS];
   limb_type             m_ff;
   logic [SHIFT_W-1:0]   k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QLIMBS; i++) q_ff[i] <= '0;
         m_ff <= '0;
         k_ff <= SHIFT_RESET;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_Q_LIMB_0: q_ff[0] <= csr_wdata;
            CSR_Q_LIMB_1: q_ff[1] <= csr_wdata;
            CSR_Q_LIMB_2: q_ff[2] <= csr_wdata;
            CSR_BARRETT:  m_ff    <= csr_wdata;
            CSR_SHIFT_K:  k_ff    <= csr_wdata[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [STAGES-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[STAGES-1] = !v_ff[STAGES-1] || rsp_ch.ready;
      for (int i = STAGES - 2; i >= 0; i--) adv[i] = !v_ff[i] || adv[i+1];
      v_in = {v_ff[STAGES-2:0], req_ch.valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) if (adv[i]) v_ff[i] <= v_in[i];
      end
   end

   assign req_ch.ready = adv[0];

   limb_type x_in [LIMBS];
   assign x_in[0] = req_ch.coef_limb_0;
   assign x_in[1] = req_ch.coef_limb_1;
   assign x_in[2] = req_ch.coef_limb_2;
   assign x_in[3] = req_ch.coef_limb_3;

   coef_type x_ff [7];
   always_ff @(posedge clock) begin
      if (adv[0]) x_ff[0] <= {x_in[3], x_in[2], x_in[1], x_in[0]};
      for (int i = 1; i < 7; i++) if (adv[i]) x_ff[i] <= x_ff[i-1];
   end

   wide_type xm [LIMBS];
   for (genvar j = 0; j < LIMBS; j++) begin : g_xm
      mlbr_limb_mul u_mul (
         .clock (clock),
         .en_a  (adv[0]),
         .en_b  (adv[1]),
         .a     (x_in[j]),
         .b     (m_ff),
         .prod  (xm[j])
      );
   end

   prod_type p_even, p_odd, p_ff;
   always_comb begin
      p_even = '0;
      p_odd  = '0;
      for (int j = 0; j < LIMBS; j++) begin
         if (j % 2 == 0) p_even = p_even | (PROD_W'(xm[j]) << (j * LIMB_W));
         else            p_odd  = p_odd  | (PROD_W'(xm[j]) << (j * LIMB_W));
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) p_ff <= p_even + p_odd;
   end

   prod_type p_shift;
   limb_type quo_ff;
   assign p_shift = p_ff >> k_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) quo_ff <= p_shift[LIMB_W-1:0];
   end

   wide_type qm [QLIMBS];
   for (genvar j = 0; j < QLIMBS; j++) begin : g_qm
      mlbr_limb_mul u_mul (
         .clock (clock),
         .en_a  (adv[4]),
         .en_b  (adv[5]),
         .a     (q_ff[j]),
         .b     (quo_ff),
         .prod  (qm[j])
      );
   end

   coef_type qm_even, qm_odd, qm_ff, r_ff, q_full, r2, res_ff;
   always_comb begin
      qm_even = '0;
      qm_odd  = '0;
      for (int j = 0; j < QLIMBS; j++) begin
         if (j % 2 == 0) qm_even = qm_even | COEF_W'(PROD_W'(qm[j]) << (j * LIMB_W));
         else            qm_odd  = qm_odd  | COEF_W'(PROD_W'(qm[j]) << (j * LIMB_W));
      end
      q_full = '0;
      for (int j = 0; j < QLIMBS; j++) q_full[j*LIMB_W +: LIMB_W] = q_ff[j];
      r2 = r_ff - q_full;
   end

   always_ff @(posedge clock) begin
      if (adv[6]) qm_ff  <= qm_even + qm_odd;
      if (adv[7]) r_ff   <= x_ff[6] - qm_ff;
      if (adv[8]) res_ff <= (r2[COEF_W-1 -: LIMB_W] == '0) ? r2 : r_ff;
   end

   assign rsp_ch.valid      = v_ff[STAGES-1];
   assign rsp_ch.res_limb_0 = res_ff[0*LIMB_W +: LIMB_W];
   assign rsp_ch.res_limb_1 = res_ff[1*LIMB_W +: LIMB_W];
   assign rsp_ch.res_limb_2 = res_ff[2*LIMB_W +: LIMB_W];
   assign rsp_ch.res_limb_3 = res_ff[3*LIMB_W +: LIMB_W];
endmodule

// ===== sv/mlbr_checker.sv =====
module mlbr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mlbr_pkg::limb_type res_limb_0,
   input mlbr_pkg::limb_type res_limb_3
);
   import mlbr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(res_limb_0) && $stable(res_limb_3))
      else $error("stalled response changed");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_flow: assert property (@(posedge clock) rsp_ready |-> req_ready)
      else $error("request refused while response side drains");

   a_empty_out: assert property (@(posedge clock) !rsp_valid |-> req_ready)
      else $error("request refused with output stage empty");

   a_no_idle_rsp: assert property (@(posedge clock) disable iff (reset)
      (!req_valid && rsp_ready) [*9] |=> !rsp_valid)
      else $error("response without request");
endmodule

bind multi_limb_barrett_reduce mlbr_checker u_mlbr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .res_limb_0 (rsp_ch.res_limb_0),
   .res_limb_3 (rsp_ch.res_limb_3)
);
